>>> rtl/ddwsyi_pkg.sv
// shared widths, constants, sequencer states and command types of the wheel-rate block
`timescale 1ns / 1ps
package ddwsyi_pkg;

    // configuration registers
    localparam int unsigned REG_W      = 31;
    localparam int unsigned CFG_ADDR_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TRACK_WIDTH      = 2'd0,
        REG_DIAMETER         = 2'd1,
        REG_MAX_LINEAR_SPEED = 2'd2,
        REG_INTEGRAL_GAIN    = 2'd3
    } cfg_reg_t;

    // stream payloads
    localparam int unsigned SPEED_W     = 32;
    localparam int unsigned DT_IN_W     = 16;
    localparam int unsigned DT_W        = 13;
    localparam int unsigned IN_TDATA_W  = 3 * SPEED_W + DT_IN_W;
    localparam int unsigned OUT_TDATA_W = 2 * SPEED_W;

    // serial multiplier
    localparam int unsigned MUL_A_W = 48;
    localparam int unsigned MUL_B_W = 31;
    localparam int unsigned PROD_W  = 64;

    // serial divider
    localparam int unsigned DIV_REM_W = 47;
    localparam int unsigned DIV_Q_W   = 32;
    localparam int unsigned DIV_CNT_W = 6;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FACTOR = 6'd16;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_RATE   = 6'd32;

    // datapath widths
    localparam int unsigned ROT_W    = 47;
    localparam int unsigned FACTOR_W = 17;
    localparam int unsigned INTEG_W  = 18;

    localparam logic [DT_W-1:0]            DT_MAX     = 13'd6554;
    localparam logic [FACTOR_W-1:0]        FACTOR_ONE = 17'h10000;
    localparam logic signed [INTEG_W-1:0]  INTEG_MAX  = 18'sd9830;
    localparam logic signed [INTEG_W-1:0]  INTEG_MIN  = -18'sd9830;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ROT_GO,
        ST_ROT_WAIT,
        ST_FAC_GO,
        ST_FAC_WAIT,
        ST_P_GO,
        ST_P_WAIT,
        ST_T_GO,
        ST_T_WAIT,
        ST_ROT_ADD,
        ST_VL_GO,
        ST_VL_WAIT,
        ST_VR_GO,
        ST_VR_WAIT,
        ST_RL_GO,
        ST_RL_WAIT,
        ST_RR_GO,
        ST_RR_WAIT,
        ST_OUT
    } seq_state_t;

endpackage

>>> rtl/ddwsyi_smul.sv
// bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier, lsb first
`timescale 1ns / 1ps
module ddwsyi_smul (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [ddwsyi_pkg::MUL_A_W-1:0]  a,
    input  logic        [ddwsyi_pkg::MUL_B_W-1:0]  b,
    output logic                                   done,
    output logic signed [ddwsyi_pkg::PROD_W-1:0]   prod
);
    import ddwsyi_pkg::*;

    logic                      busy_reg;
    logic                      done_reg;
    logic signed [PROD_W-1:0]  mcand_reg;
    logic signed [PROD_W-1:0]  acc_reg;
    logic [MUL_B_W-1:0]        mplier_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (mplier_reg[MUL_B_W-1:1] == '0)) begin
                // remaining multiplier bits are all zero
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= PROD_W'(a);
            acc_reg    <= '0;
            mplier_reg <= b;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MUL_B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> rtl/ddwsyi_sdiv.sv
// bit-serial restoring divider, one quotient bit per cycle, remainder start below divisor
`timescale 1ns / 1ps
module ddwsyi_sdiv (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ddwsyi_pkg::div_cmd_t              cmd,
    input  logic [ddwsyi_pkg::DIV_REM_W-1:0]  rem_init,
    input  logic [ddwsyi_pkg::DIV_REM_W-1:0]  divisor,
    input  logic [ddwsyi_pkg::DIV_Q_W-1:0]    low,
    output logic                              done,
    output logic [ddwsyi_pkg::DIV_Q_W-1:0]    quot
);
    import ddwsyi_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIV_REM_W-1:0]  rem_reg;
    logic [DIV_REM_W-1:0]  dvs_reg;
    logic [DIV_Q_W-1:0]    q_reg;

    logic [DIV_REM_W:0]    trial;
    logic [DIV_REM_W:0]    diff;
    logic                  ge;

    // low bits of the dividend leave the top of q_reg as quotient bits enter below
    assign trial = {rem_reg, q_reg[DIV_Q_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rem_reg <= rem_init;
            dvs_reg <= divisor;
            q_reg   <= low;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
            q_reg   <= {q_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> rtl/diff_drive_wheel_speed_yaw_integral.sv
// top level: differential-drive wheel-rate command with yaw-rate integral correction
`timescale 1ns / 1ps
// One command item in on the s_ channel gives one wheel-rate item on the m_ channel.
// s_tdata carries linear speed, commanded yaw rate, measured yaw rate (Q16.16) and
// the elapsed time (Q0.16); m_tdata carries the left and right wheel rates (Q16.16).
// Geometry, speed limit and integral gain are set through cfg_we/cfg_addr/cfg_wdata
// while no item is in flight.
// Items are handled one at a time by a sequencer around a bit-serial multiplier and
// a bit-serial divider, each doing one bit per cycle. The multiplier stops once its
// remaining multiplier bits are zero, the speed-limit division takes 16 steps and
// each wheel division 32 steps, skipped when the result saturates anyway.
// s_tready is high only while the sequencer is idle. The result sits in an output
// register, so the next item is taken while m_tvalid waits for m_tready; a stalled
// receiver only holds the sequencer at its final step.
// Synchronous reset restores the default geometry, gain and limit, clears the yaw
// integral and drops m_tvalid.
module diff_drive_wheel_speed_yaw_integral (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // linear_speed_cmd, yaw_rate_cmd, yaw_rate_measured, elapsed_time
    input  logic [ddwsyi_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // left_wheel_rate, right_wheel_rate
    output logic [ddwsyi_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_we,
    input  logic [ddwsyi_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ddwsyi_pkg::REG_W-1:0]          cfg_wdata
);
    import ddwsyi_pkg::*;

    localparam logic [SPEED_W-1:0] RATE_MAX = 32'h7fff_ffff;
    localparam logic [SPEED_W-1:0] RATE_MIN = 32'h8000_0000;

    seq_state_t state_reg, state_next;

    logic [REG_W-1:0] tw_reg, dia_reg, mls_reg, ki_reg;

    logic signed [SPEED_W-1:0]   v_reg, wc_reg, wm_reg;
    logic [DT_W-1:0]             dt_reg;
    logic signed [ROT_W-1:0]     rot_reg, sum_reg;
    logic [FACTOR_W-1:0]         factor_reg;
    logic signed [MUL_A_W-1:0]   p_reg;
    logic signed [INTEG_W-1:0]   yi_reg;
    logic [ROT_W-1:0]            vl_mag_reg, vr_mag_reg;
    logic                        vl_neg_reg, vr_neg_reg;
    logic [SPEED_W-1:0]          left_reg, right_reg;
    logic [OUT_TDATA_W-1:0]      m_tdata_reg;
    logic                        m_tvalid_reg;

    // input fields
    logic [DT_IN_W-1:0] dt_in;
    logic [DT_W-1:0]    dt_clamped;

    // multiplier
    logic                        mul_start, mul_done;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic signed [PROD_W-1:0]    mul_prod;
    logic signed [MUL_A_W-1:0]   prod_q16;
    logic signed [MUL_A_W-1:0]   prod_q16_neg;
    logic signed [ROT_W-1:0]     rot_new, sum_new;

    // divider
    div_cmd_t                    div_cmd;
    logic [DIV_REM_W-1:0]        div_rem_init, div_divisor;
    logic [DIV_Q_W-1:0]          div_low, div_quot;
    logic                        div_done;

    logic signed [SPEED_W:0]     wdiff;
    logic signed [ROT_W-1:0]     spd_l, spd_r;
    logic                        sum_gt, sum_nz;
    logic signed [MUL_A_W-1:0]   integ_acc;
    logic signed [INTEG_W-1:0]   integ_new;
    logic [REG_W-1:0]            dia_eff;
    logic [ROT_W-1:0]            rate_mag;
    logic                        rate_neg, rate_ovf;
    logic [SPEED_W-1:0]          rate_sat, rate_q;
    logic                        out_load;

    assign dt_in      = s_tdata[IN_TDATA_W-1 -: DT_IN_W];
    assign dt_clamped = (dt_in > DT_IN_W'(DT_MAX)) ? DT_MAX : dt_in[DT_W-1:0];

    assign prod_q16     = mul_prod[PROD_W-1:PROD_W-MUL_A_W];
    assign prod_q16_neg = MUL_A_W'(0) - prod_q16;
    assign rot_new      = mul_prod[PROD_W-1:PROD_W-ROT_W];
    assign sum_new      = ROT_W'(v_reg) + rot_new;

    assign wdiff  = (SPEED_W+1)'(wc_reg) - (SPEED_W+1)'(wm_reg);
    assign spd_l  = ROT_W'(v_reg) + rot_reg;
    assign spd_r  = ROT_W'(v_reg) - rot_reg;
    assign sum_gt = (sum_reg > $signed(ROT_W'(mls_reg)));
    assign sum_nz = (sum_reg != '0);

    // integral update with clamp
    assign integ_acc = MUL_A_W'(yi_reg) + prod_q16;
    always_comb begin
        if (integ_acc > MUL_A_W'(INTEG_MAX)) begin
            integ_new = INTEG_MAX;
        end else if (integ_acc < MUL_A_W'(INTEG_MIN)) begin
            integ_new = INTEG_MIN;
        end else begin
            integ_new = integ_acc[INTEG_W-1:0];
        end
    end

    // wheel rate: |v| * 2^17 / diameter, with saturation decided on the top word
    assign dia_eff  = (dia_reg == '0) ? REG_W'(1) : dia_reg;
    assign rate_mag = (state_reg == ST_RR_GO) ? vr_mag_reg : vl_mag_reg;
    assign rate_neg = ((state_reg == ST_RR_GO) || (state_reg == ST_RR_WAIT)) ?
                      vr_neg_reg : vl_neg_reg;
    assign rate_ovf = (rate_mag[ROT_W-1 -: DIV_Q_W] >= {1'b0, dia_eff});
    assign rate_sat = rate_neg ? RATE_MIN : RATE_MAX;

    always_comb begin
        if (rate_neg) begin
            rate_q = (div_quot > RATE_MIN) ? RATE_MIN : (SPEED_W'(0) - div_quot);
        end else begin
            rate_q = (div_quot > RATE_MAX) ? RATE_MAX : div_quot;
        end
    end

    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_ROT_GO;
            ST_ROT_GO:   state_next = ST_ROT_WAIT;
            ST_ROT_WAIT: if (mul_done) state_next = ST_FAC_GO;
            ST_FAC_GO:   state_next = sum_gt ? ST_FAC_WAIT : ST_P_GO;
            ST_FAC_WAIT: if (div_done) state_next = ST_P_GO;
            ST_P_GO:     state_next = sum_nz ? ST_P_WAIT : ST_VL_GO;
            ST_P_WAIT:   if (mul_done) state_next = ST_T_GO;
            ST_T_GO:     state_next = ST_T_WAIT;
            ST_T_WAIT:   if (mul_done) state_next = ST_ROT_ADD;
            ST_ROT_ADD:  state_next = ST_VL_GO;
            ST_VL_GO:    state_next = ST_VL_WAIT;
            ST_VL_WAIT:  if (mul_done) state_next = ST_VR_GO;
            ST_VR_GO:    state_next = ST_VR_WAIT;
            ST_VR_WAIT:  if (mul_done) state_next = ST_RL_GO;
            ST_RL_GO:    state_next = rate_ovf ? ST_RR_GO : ST_RL_WAIT;
            ST_RL_WAIT:  if (div_done) state_next = ST_RR_GO;
            ST_RR_GO:    state_next = rate_ovf ? ST_OUT : ST_RR_WAIT;
            ST_RR_WAIT:  if (div_done) state_next = ST_OUT;
            ST_OUT:      if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready      = 1'b0;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_cmd.start = 1'b0;
        div_cmd.steps = DIV_STEPS_RATE;
        div_rem_init  = DIV_REM_W'(rate_mag[ROT_W-1 -: DIV_Q_W]);
        div_divisor   = DIV_REM_W'(dia_eff);
        div_low       = {rate_mag[ROT_W-DIV_Q_W-1:0], (DIV_Q_W-ROT_W+DIV_Q_W)'(0)};
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_ROT_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(wc_reg);
                mul_b     = tw_reg;
            end
            ST_FAC_GO: begin
                div_cmd.start = sum_gt;
                div_cmd.steps = DIV_STEPS_FACTOR;
                div_rem_init  = DIV_REM_W'(mls_reg);
                div_divisor   = sum_reg;
                div_low       = '0;
            end
            ST_P_GO: begin
                mul_start = sum_nz;
                mul_a     = MUL_A_W'(wdiff);
                mul_b     = ki_reg;
            end
            ST_T_GO: begin
                mul_start = 1'b1;
                mul_a     = p_reg;
                mul_b     = MUL_B_W'(dt_reg);
            end
            ST_VL_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(spd_l);
                mul_b     = MUL_B_W'(factor_reg);
            end
            ST_VR_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(spd_r);
                mul_b     = MUL_B_W'(factor_reg);
            end
            ST_RL_GO: begin
                div_cmd.start = !rate_ovf;
            end
            ST_RR_GO: begin
                div_cmd.start = !rate_ovf;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tw_reg  <= 31'd327680;
            dia_reg <= 31'd327680;
            mls_reg <= 31'd65536;
            ki_reg  <= 31'd65536;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TRACK_WIDTH:      tw_reg  <= cfg_wdata;
                REG_DIAMETER:         dia_reg <= cfg_wdata;
                REG_MAX_LINEAR_SPEED: mls_reg <= cfg_wdata;
                REG_INTEGRAL_GAIN:    ki_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yi_reg <= '0;
        end else if ((state_reg == ST_T_WAIT) && mul_done) begin
            yi_reg <= integ_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    v_reg  <= s_tdata[SPEED_W-1:0];
                    wc_reg <= s_tdata[2*SPEED_W-1:SPEED_W];
                    wm_reg <= s_tdata[3*SPEED_W-1:2*SPEED_W];
                    dt_reg <= dt_clamped;
                end
            end
            ST_ROT_WAIT: begin
                if (mul_done) begin
                    rot_reg <= rot_new;
                    sum_reg <= sum_new;
                end
            end
            ST_FAC_GO: begin
                factor_reg <= FACTOR_ONE;
            end
            ST_FAC_WAIT: begin
                if (div_done) begin
                    factor_reg <= FACTOR_W'(div_quot[FACTOR_W-2:0]);
                end
            end
            ST_P_WAIT: begin
                if (mul_done) begin
                    p_reg <= prod_q16;
                end
            end
            ST_ROT_ADD: begin
                rot_reg <= rot_reg + ROT_W'(yi_reg);
            end
            ST_VL_WAIT: begin
                if (mul_done) begin
                    vl_neg_reg <= prod_q16[MUL_A_W-1];
                    vl_mag_reg <= prod_q16[MUL_A_W-1] ? prod_q16_neg[ROT_W-1:0] :
                                                        prod_q16[ROT_W-1:0];
                end
            end
            ST_VR_WAIT: begin
                if (mul_done) begin
                    vr_neg_reg <= prod_q16[MUL_A_W-1];
                    vr_mag_reg <= prod_q16[MUL_A_W-1] ? prod_q16_neg[ROT_W-1:0] :
                                                        prod_q16[ROT_W-1:0];
                end
            end
            ST_RL_GO: begin
                if (rate_ovf) begin
                    left_reg <= rate_sat;
                end
            end
            ST_RL_WAIT: begin
                if (div_done) begin
                    left_reg <= rate_q;
                end
            end
            ST_RR_GO: begin
                if (rate_ovf) begin
                    right_reg <= rate_sat;
                end
            end
            ST_RR_WAIT: begin
                if (div_done) begin
                    right_reg <= rate_q;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_tdata_reg <= {right_reg, left_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    ddwsyi_smul u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    ddwsyi_sdiv u_sdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .rem_init (div_rem_init),
        .divisor  (div_divisor),
        .low      (div_low),
        .done     (div_done),
        .quot     (div_quot)
    );

    // integral never leaves its clamp range
    a_integral_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (yi_reg <= INTEG_MAX) && (yi_reg >= INTEG_MIN))
        else $error("yaw integral outside clamp range");

    // integral only moves on the update step
    a_integral_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !((state_reg == ST_T_WAIT) && mul_done) |=> $stable(yi_reg))
        else $error("yaw integral changed outside its update step");

    // restoring division needs the starting remainder below the divisor
    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        div_cmd.start |-> (div_rem_init < div_divisor))
        else $error("divider started with remainder not below divisor");

    // a product only completes while the sequencer waits for it
    a_mul_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> ((state_reg == ST_ROT_WAIT) || (state_reg == ST_P_WAIT) ||
                      (state_reg == ST_T_WAIT) || (state_reg == ST_VL_WAIT) ||
                      (state_reg == ST_VR_WAIT)))
        else $error("multiplier finished outside a wait step");

endmodule

>>> test/tb_diff_drive_wheel_speed_yaw_integral.sv
// self-checking testbench for the differential-drive wheel-rate block with yaw integral
`timescale 1ns / 1ps
module tb_diff_drive_wheel_speed_yaw_integral;
    import ddwsyi_pkg::*;

    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     DRAIN_CYCLES   = 300;
    localparam int     MAX_GAP        = 12;
    localparam int     RANDOM_PHASES  = 8;
    localparam int     PHASE_ITEMS    = 105;
    localparam int     CORNER_ITEMS   = 60;
    localparam int     MAX_REPORTS    = 10;
    localparam longint DT_CLAMP       = 6554;
    localparam longint INTEG_CLAMP    = 9830;
    localparam longint ONE_Q16        = 65536;

    localparam logic [REG_W-1:0] REG_FULL  = '1;
    localparam logic [31:0]      WORD_MIN  = 32'h8000_0000;
    localparam logic [31:0]      WORD_MAX  = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [DT_IN_W-1:0] elapsed_time;
        logic [SPEED_W-1:0] yaw_rate_measured;
        logic [SPEED_W-1:0] yaw_rate_cmd;
        logic [SPEED_W-1:0] linear_speed;
    } wheel_cmd_t;

    typedef struct packed {
        logic [SPEED_W-1:0] right_rate;
        logic [SPEED_W-1:0] left_rate;
    } wheel_rates_t;

    class wheel_rate_scoreboard;
        logic [REG_W-1:0] track_width;
        logic [REG_W-1:0] diameter;
        logic [REG_W-1:0] speed_limit;
        logic [REG_W-1:0] integral_gain;
        longint           yaw_integral;
        wheel_rates_t     expected_rates[$];
        int               mismatches;

        function new();
            track_width    = 31'd327680;
            diameter       = 31'd327680;
            speed_limit    = 31'd65536;
            integral_gain  = 31'd65536;
            yaw_integral   = 0;
            mismatches     = 0;
        endfunction

        function void write_reg(cfg_reg_t r, logic [REG_W-1:0] val);
            case (r)
                REG_TRACK_WIDTH:      track_width    = val;
                REG_DIAMETER:         diameter       = val;
                REG_MAX_LINEAR_SPEED: speed_limit    = val;
                REG_INTEGRAL_GAIN:    integral_gain  = val;
                default: ;
            endcase
        endfunction

        function logic [SPEED_W-1:0] saturate(longint x);
            if (x > longint'(32'sh7FFF_FFFF))
                return WORD_MAX;
            if (x < longint'(32'sh8000_0000))
                return WORD_MIN;
            return x[SPEED_W-1:0];
        endfunction

        // advances the yaw integral and returns both wheel rates
        function wheel_rates_t step_wheel_rates(wheel_cmd_t c);
            longint       v, wc, wm, dt, rot, sum, factor, p, acc, vl, vr, dia;
            wheel_rates_t r;
            v  = longint'($signed(c.linear_speed));
            wc = longint'($signed(c.yaw_rate_cmd));
            wm = longint'($signed(c.yaw_rate_measured));
            dt = longint'(c.elapsed_time);
            if (dt > DT_CLAMP)
                dt = DT_CLAMP;
            rot = (wc * longint'(track_width)) >>> 17;
            sum = v + rot;
            if (sum > longint'(speed_limit))
                factor = (longint'(speed_limit) * ONE_Q16) / sum;
            else
                factor = ONE_Q16;
            // a zero sum leaves the integral untouched and out of the rim speed
            if (sum != 0) begin
                p   = (longint'(integral_gain) * (wc - wm)) >>> 16;
                acc = yaw_integral + ((p * dt) >>> 16);
                if (acc > INTEG_CLAMP)
                    acc = INTEG_CLAMP;
                if (acc < -INTEG_CLAMP)
                    acc = -INTEG_CLAMP;
                yaw_integral = acc;
                rot += yaw_integral;
            end
            vl  = ((v + rot) * factor) >>> 16;
            vr  = ((v - rot) * factor) >>> 16;
            dia = (diameter == 0) ? 1 : longint'(diameter);
            r.left_rate  = saturate((vl * 131072) / dia);
            r.right_rate = saturate((vr * 131072) / dia);
            return r;
        endfunction

        function void note_command(wheel_cmd_t c);
            expected_rates.insert(expected_rates.size(), step_wheel_rates(c));
        endfunction

        function void check_rates(wheel_rates_t got);
            wheel_rates_t want;
            if (expected_rates.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected wheel-rate item: left %h right %h",
                             got.left_rate, got.right_rate);
                return;
            end
            want = expected_rates.pop_front();
            if (got.left_rate !== want.left_rate) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("left wheel rate: expected %h, got %h",
                             want.left_rate, got.left_rate);
            end
            if (got.right_rate !== want.right_rate) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("right wheel rate: expected %h, got %h",
                             want.right_rate, got.right_rate);
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_we;
    cfg_reg_t               cfg_addr;
    logic [REG_W-1:0]       cfg_wdata;

    wheel_rate_scoreboard sb;
    bit                   no_gaps;
    int                   idle_cycles;

    diff_drive_wheel_speed_yaw_integral i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_command(wheel_cmd_t'(s_tdata));
        if (aresetn && m_tvalid && m_tready)
            sb.check_rates(wheel_rates_t'(m_tdata));
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: stalls are counted from the moment a result is offered
    initial begin : receiver
        int   stall;
        logic seen;
        m_tready <= 1'b1;
        @(posedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                m_tready <= 1'b0;
                do @(negedge aclk); while (m_tvalid !== 1'b1);
                repeat (stall) @(posedge aclk);
                m_tready <= 1'b1;
            end
            do begin
                @(negedge aclk);
                seen = (m_tvalid === 1'b1) && (aresetn === 1'b1);
                @(posedge aclk);
            end while (!seen);
        end
    end

    // entered and left at a rising edge; valid stays high when no gap follows
    task automatic send_cmd(input wheel_cmd_t c);
        int   gap;
        logic taken;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        do begin
            @(negedge aclk);
            taken = (s_tready === 1'b1);
            @(posedge aclk);
        end while (!taken);
    endtask

    // waits on the clock first so the last accepted item is already in the queue
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_rates.size() != 0)
            @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_reg_t r, input logic [REG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= val;
        sb.write_reg(r, val);
        @(posedge aclk);
    endtask

    task automatic configure(input logic [REG_W-1:0] tw, dia, lim, gain);
        put_reg(REG_TRACK_WIDTH, tw);
        put_reg(REG_DIAMETER, dia);
        put_reg(REG_MAX_LINEAR_SPEED, lim);
        put_reg(REG_INTEGRAL_GAIN, gain);
        cfg_we <= 1'b0;
    endtask

    function automatic wheel_cmd_t mk(input logic [31:0] v, wc, wm,
                                      input logic [DT_IN_W-1:0] dt);
        wheel_cmd_t c;
        c.linear_speed      = v;
        c.yaw_rate_cmd      = wc;
        c.yaw_rate_measured = wm;
        c.elapsed_time      = dt;
        return c;
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 5))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return 32'd0;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DT_IN_W-1:0] corner_dt();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd6553;
            2:       return 16'd6554;
            3:       return 16'd6555;
            4:       return 16'hFFFF;
            default: return DT_IN_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic wheel_cmd_t random_cmd();
        wheel_cmd_t  c;
        int unsigned mode;
        longint      rot, v;
        mode = $urandom_range(0, 99);
        // plausible robot motion by default
        c.linear_speed      = $urandom_range(0, 6 * 65536) - 3 * 65536;
        c.yaw_rate_cmd      = $urandom_range(0, 8 * 65536) - 4 * 65536;
        c.yaw_rate_measured = c.yaw_rate_cmd + $urandom_range(0, 2 * 65536) - 65536;
        c.elapsed_time      = ($urandom_range(0, 4) == 0) ?
                              DT_IN_W'($urandom_range(0, 65535)) :
                              DT_IN_W'($urandom_range(0, 7000));
        rot = ($signed(c.yaw_rate_cmd) * longint'(sb.track_width)) >>> 17;
        if (mode < 12) begin
            c.linear_speed      = $urandom;
            c.yaw_rate_cmd      = $urandom;
            c.yaw_rate_measured = $urandom;
            c.elapsed_time      = DT_IN_W'($urandom_range(0, 65535));
        end else if (mode < 24) begin
            c.linear_speed      = corner_word();
            c.yaw_rate_cmd      = corner_word();
            c.yaw_rate_measured = corner_word();
            c.elapsed_time      = corner_dt();
        end else if (mode < 36) begin
            // forward speed cancels the rim speed exactly
            v = -rot;
            if (longint'(int'(v)) == v) begin
                c.linear_speed = v[31:0];
            end else begin
                c.linear_speed = '0;
                c.yaw_rate_cmd = '0;
            end
        end else if (mode < 44) begin
            // sum lands right on the speed limit
            v = longint'(sb.speed_limit) - rot;
            if (longint'(int'(v)) == v)
                c.linear_speed = v[31:0];
        end else if (mode < 56) begin
            c.linear_speed = $urandom_range(65536, 1 << 26);
        end
        return c;
    endfunction

    function automatic logic [REG_W-1:0] random_reg_value(input int unsigned lo, hi);
        case ($urandom_range(0, 9))
            0, 1:    return REG_W'($urandom);
            2:       return REG_W'($urandom_range(0, 8));
            default: return REG_W'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic random_items(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send_cmd(random_cmd());
        end
    endtask

    task automatic run_directed();
        send_cmd(mk(32'd0, 32'd0, 32'd0, 16'd0));
        send_cmd(mk(32'h0001_0000, 32'd0, 32'd0, 16'd6554));
        send_cmd(mk(32'h0002_0000, 32'd0, 32'd0, 16'd6553));
        send_cmd(mk(32'd0, 32'h0001_0000, 32'd0, 16'd6554));
        // drive the integral into both clamps, elapsed time beyond its limit
        repeat (3) send_cmd(mk(32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000, 16'hFFFF));
        repeat (3) send_cmd(mk(32'hFFFF_8000, 32'hFFFF_0000, 32'h0001_0000, 16'd6555));
        // zero sum at default geometry: integral held
        send_cmd(mk(32'hFFFD_8000, 32'h0001_0000, 32'd0, 16'd6554));
        send_cmd(mk(WORD_MIN, 32'd0, 32'd0, 16'd1));
        send_cmd(mk(WORD_MAX, 32'd0, 32'd0, 16'd1));
        send_cmd(mk(32'd0, WORD_MAX, WORD_MIN, 16'hFFFF));
        send_cmd(mk(32'd0, WORD_MIN, WORD_MAX, 16'hFFFF));
        send_cmd(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1));
        send_cmd(mk(WORD_MAX, WORD_MAX, 32'd0, 16'h8000));
        send_cmd(mk(WORD_MIN, WORD_MIN, WORD_MIN, 16'd0));
        send_cmd(mk(32'hFFFD_0000, 32'd0, 32'd1, 16'd100));
        send_cmd(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA));
        send_cmd(mk(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555));
    endtask

    initial begin : stimulus
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_TRACK_WIDTH;
        cfg_wdata <= '0;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        random_items(PHASE_ITEMS);
        finish_phase();

        // zero geometry, zero diameter, no limit headroom, no gain
        configure('0, '0, '0, '0);
        random_items(CORNER_ITEMS);
        finish_phase();

        configure(REG_FULL, REG_FULL, REG_FULL, REG_FULL);
        random_items(CORNER_ITEMS);
        finish_phase();

        configure(REG_FULL, 31'd1, '0, REG_FULL);
        random_items(CORNER_ITEMS);
        finish_phase();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            configure(random_reg_value(13107, 65536), random_reg_value(3277, 65536),
                      random_reg_value(0, 327680), random_reg_value(0, 524288));
            random_items(PHASE_ITEMS);
            finish_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_rates.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
